>>> hdl/octpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// octpd_pkg
// Shared types and constants of the octree point descent engine.
// ----------------------------------------------------------------------------
package octpd_pkg;

	localparam int POOL_NODES  = 4096;
	localparam int NODE_W      = $clog2(POOL_NODES);
	localparam int USED_W      = NODE_W + 1;
	localparam int DEPTH_BOUND = 15;
	localparam int DEPTH_W     = 4;
	localparam int CHILDREN    = 8;
	localparam int OCT_W       = 3;
	localparam int COORD_W     = 32;
	localparam int DATA_W      = 64;
	localparam int CFG_IDX_W   = 3;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_BAD  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEPTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_X      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_Z      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_X      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_Z      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_DATA = 3'd7;

	typedef enum logic [1:0] {
		OP_SPLIT  = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_SET    = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DESC,
		ST_ALLOC,
		ST_STEP,
		ST_SET,
		ST_RD,
		ST_EMIT
	} st_t;

	typedef struct packed {
		logic [DEPTH_W-1:0]        max_depth;
		logic signed [COORD_W-1:0] min_x;
		logic signed [COORD_W-1:0] min_y;
		logic signed [COORD_W-1:0] min_z;
		logic signed [COORD_W-1:0] max_x;
		logic signed [COORD_W-1:0] max_y;
		logic signed [COORD_W-1:0] max_z;
		logic [DATA_W-1:0]         empty_data;
	} cfg_t;

	typedef struct packed {
		op_t                       op;
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
		logic signed [COORD_W-1:0] pz;
		logic [NODE_W-1:0]         sel;
		logic [DATA_W-1:0]         data;
	} item_t;

	typedef struct packed {
		logic pop;
	} qctl_t;

endpackage

>>> hdl/octpd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// octpd_in_if / octpd_out_if
// Request and response channels of the octree point descent engine.
// ----------------------------------------------------------------------------
interface octpd_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         func;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] point_z;
	logic [11:0]        node_sel;
	logic [63:0]        data_in;

	modport source (output valid, func, point_x, point_y, point_z, node_sel, data_in,
		input ready);
	modport sink (input valid, func, point_x, point_y, point_z, node_sel, data_in,
		output ready);
endinterface

interface octpd_out_if;
	logic        valid;
	logic        ready;
	logic [11:0] node_out;
	logic [3:0]  depth_out;
	logic [63:0] data_out;
	logic        is_leaf;
	logic [11:0] first_child;
	logic [11:0] parent_out;
	logic [1:0]  status;

	modport source (output valid, node_out, depth_out, data_out, is_leaf, first_child,
		parent_out, status, input ready);
	modport sink (input valid, node_out, depth_out, data_out, is_leaf, first_child,
		parent_out, status, output ready);
endinterface

>>> hdl/octpd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// octpd_front
// Accepts request items, decodes the operation and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module octpd_front (
	input  logic           clk,
	input  logic           arst_n,
	octpd_in_if.sink       in_ch,
	output octpd_pkg::item_t q_item,
	input  octpd_pkg::qctl_t q_ctl_in,
	output logic           q_valid
);
	import octpd_pkg::*;

	item_t      ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;
	item_t      dec;

	always_comb begin
		dec.op   = op_t'(in_ch.func);
		dec.px   = in_ch.point_x;
		dec.py   = in_ch.point_y;
		dec.pz   = in_ch.point_z;
		dec.sel  = in_ch.node_sel;
		dec.data = in_ch.data_in;
	end

	assign in_ch.ready = (count_q != 2'd2);
	assign push        = in_ch.valid && in_ch.ready;
	assign pop         = q_ctl_in.pop && (count_q != 2'd0);
	assign q_valid     = (count_q != 2'd0);
	assign q_item      = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

>>> hdl/octpd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// octpd_back
// Node pool and descent sequencer: walks one level a cycle, allocates
// eight children in turn, and registers the response item.
// ----------------------------------------------------------------------------
module octpd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  octpd_pkg::cfg_t  cfg,
	input  octpd_pkg::item_t q_item,
	input  logic             q_valid,
	output octpd_pkg::qctl_t q_ctl,
	octpd_out_if.source      out_ch
);
	import octpd_pkg::*;

	// node 0 lives in flops, every other node in the pool memories
	logic [NODE_W:0]           link_mem [POOL_NODES];
	logic [NODE_W+DEPTH_W-1:0] info_mem [POOL_NODES];
	logic [DATA_W-1:0]         data_mem [POOL_NODES];
	logic [NODE_W:0]           link_rd_q;
	logic [NODE_W+DEPTH_W-1:0] info_rd_q;
	logic [DATA_W-1:0]         data_rd_q;

	st_t                       state_q, state_d;
	op_t                       op_q;
	logic [NODE_W-1:0]         idx_q, base_q;
	logic [DEPTH_W-1:0]        depth_q;
	logic [USED_W-1:0]         used_q;
	logic [OCT_W-1:0]          cnt_q;
	logic [1:0]                status_q;
	logic                      root_leaf_q;
	logic [NODE_W-1:0]         root_child_q;
	logic [DATA_W-1:0]         root_data_q;
	logic signed [COORD_W-1:0] lo_q [3];
	logic signed [COORD_W-1:0] hi_q [3];
	logic signed [COORD_W-1:0] pt_q [3];
	logic [DATA_W-1:0]         dat_q;

	logic                      is_root, cur_leaf, at_limit, full, bad, out_free;
	logic [NODE_W-1:0]         cur_child, step_child, next_idx, rd_addr;
	logic [OCT_W-1:0]          oct;
	logic signed [COORD_W:0]   sum [3];
	logic signed [COORD_W-1:0] mid [3];
	logic signed [COORD_W-1:0] new_lo [3];
	logic signed [COORD_W-1:0] new_hi [3];
	logic                      link_we, info_we, data_we, split_go;
	logic [NODE_W-1:0]         link_wa, data_wa;
	logic [NODE_W:0]           link_wd;
	logic [DATA_W-1:0]         data_wd;

	assign is_root    = (idx_q == '0);
	assign cur_leaf   = is_root ? root_leaf_q : link_rd_q[NODE_W];
	assign cur_child  = is_root ? root_child_q : link_rd_q[NODE_W-1:0];
	assign at_limit   = (depth_q >= cfg.max_depth) || (32'(depth_q) >= DEPTH_BOUND);
	assign full       = (used_q > USED_W'(POOL_NODES - CHILDREN));
	assign bad        = ({1'b0, q_item.sel} >= used_q);
	assign out_free   = !out_ch.valid || out_ch.ready;
	assign step_child = (state_q == ST_STEP) ? base_q : cur_child;
	assign split_go   = !at_limit && cur_leaf && (op_q == OP_SPLIT) && !full;

	// octant from point against box centre, centre taken at 33 bits
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			sum[a] = {lo_q[a][COORD_W-1], lo_q[a]} + {hi_q[a][COORD_W-1], hi_q[a]};
			mid[a] = sum[a][COORD_W:1];
			oct[a] = (pt_q[a] >= mid[a]);
			new_lo[a] = oct[a] ? mid[a] : lo_q[a];
			new_hi[a] = oct[a] ? hi_q[a] : mid[a];
		end
	end
	assign next_idx = step_child + NODE_W'(oct);
	// hold the read address while the response waits
	assign rd_addr  = (state_q == ST_RD || state_q == ST_EMIT) ? idx_q : next_idx;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					if (q_item.op == OP_SPLIT || q_item.op == OP_LOOKUP)
						state_d = ST_DESC;
					else if (bad)
						state_d = ST_EMIT;
					else if (q_item.op == OP_SET)
						state_d = ST_SET;
					else
						state_d = ST_RD;
				end
			end
			ST_DESC: begin
				if (at_limit || (cur_leaf && !split_go))
					state_d = ST_RD;
				else if (split_go)
					state_d = ST_ALLOC;
			end
			ST_ALLOC: begin
				if (cnt_q == OCT_W'(CHILDREN - 1))
					state_d = ST_STEP;
			end
			ST_STEP: state_d = ST_DESC;
			ST_SET:  state_d = ST_RD;
			ST_RD:   state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// queue pop and memory write controls
	always_comb begin
		q_ctl.pop   = (state_q == ST_IDLE) && q_valid;
		link_we = 1'b0;
		link_wa = idx_q;
		link_wd = {1'b0, used_q[NODE_W-1:0]};
		info_we = 1'b0;
		data_we = 1'b0;
		data_wa = idx_q;
		data_wd = dat_q;
		unique case (state_q)
			ST_DESC: begin
				link_we = split_go && !is_root;
			end
			ST_ALLOC: begin
				link_we = 1'b1;
				link_wa = base_q + NODE_W'(cnt_q);
				link_wd = {1'b1, {NODE_W{1'b0}}};
				info_we = 1'b1;
				data_we = 1'b1;
				data_wa = base_q + NODE_W'(cnt_q);
				data_wd = cfg.empty_data;
			end
			ST_SET: begin
				data_we = !is_root;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (link_we)
			link_mem[link_wa] <= link_wd;
		if (info_we)
			info_mem[link_wa] <= {idx_q, depth_q + DEPTH_W'(1)};
		if (data_we)
			data_mem[data_wa] <= data_wd;
		link_rd_q <= link_mem[rd_addr];
		info_rd_q <= info_mem[rd_addr];
		data_rd_q <= data_mem[rd_addr];
	end

	// item payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid) begin
			pt_q[0] <= q_item.px;
			pt_q[1] <= q_item.py;
			pt_q[2] <= q_item.pz;
			dat_q   <= q_item.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			op_q         <= OP_SPLIT;
			idx_q        <= '0;
			base_q       <= '0;
			depth_q      <= '0;
			used_q       <= USED_W'(1);
			cnt_q        <= '0;
			status_q     <= STAT_OK;
			root_leaf_q  <= 1'b1;
			root_child_q <= '0;
			root_data_q  <= '1;
			for (int a = 0; a < 3; a++) begin
				lo_q[a] <= '0;
				hi_q[a] <= '0;
			end
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						op_q     <= q_item.op;
						depth_q  <= '0;
						status_q <= (q_item.op == OP_SET || q_item.op == OP_READ) && bad
							? STAT_BAD : STAT_OK;
						idx_q    <= (q_item.op == OP_SET || q_item.op == OP_READ)
							? q_item.sel : '0;
						lo_q[0] <= cfg.min_x;
						lo_q[1] <= cfg.min_y;
						lo_q[2] <= cfg.min_z;
						hi_q[0] <= cfg.max_x;
						hi_q[1] <= cfg.max_y;
						hi_q[2] <= cfg.max_z;
					end
				end
				ST_DESC: begin
					if (!at_limit) begin
						if (cur_leaf) begin
							if (op_q == OP_SPLIT && full)
								status_q <= STAT_FULL;
							if (split_go) begin
								base_q <= used_q[NODE_W-1:0];
								cnt_q  <= '0;
								if (is_root) begin
									root_leaf_q  <= 1'b0;
									root_child_q <= used_q[NODE_W-1:0];
								end
							end
						end else begin
							idx_q   <= next_idx;
							depth_q <= depth_q + DEPTH_W'(1);
							lo_q    <= new_lo;
							hi_q    <= new_hi;
						end
					end
				end
				ST_ALLOC: begin
					cnt_q <= cnt_q + OCT_W'(1);
					if (cnt_q == OCT_W'(CHILDREN - 1))
						used_q <= used_q + USED_W'(CHILDREN);
				end
				ST_STEP: begin
					idx_q   <= next_idx;
					depth_q <= depth_q + DEPTH_W'(1);
					lo_q    <= new_lo;
					hi_q    <= new_hi;
				end
				ST_SET: begin
					if (is_root)
						root_data_q <= dat_q;
				end
				default: begin
				end
			endcase
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.valid <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_ch.valid <= 1'b1;
		end else if (out_ch.ready) begin
			out_ch.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			out_ch.node_out <= idx_q;
			out_ch.status   <= status_q;
			if (status_q == STAT_BAD) begin
				out_ch.depth_out   <= '0;
				out_ch.data_out    <= '0;
				out_ch.is_leaf     <= 1'b0;
				out_ch.first_child <= '0;
				out_ch.parent_out  <= '0;
			end else begin
				out_ch.depth_out   <= is_root ? '0 : info_rd_q[DEPTH_W-1:0];
				out_ch.parent_out  <= is_root ? '0 : info_rd_q[NODE_W+DEPTH_W-1:DEPTH_W];
				out_ch.data_out    <= is_root ? root_data_q : data_rd_q;
				out_ch.is_leaf     <= cur_leaf;
				out_ch.first_child <= cur_leaf ? '0 : cur_child;
			end
		end
	end
endmodule

>>> hdl/octree_point_descent_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// octree_point_descent_engine_core
// Pooled octree with split, lookup, set and read operations.
// ----------------------------------------------------------------------------
// Items are taken into a two-entry queue and served one at a time by a
// sequencer over a 4096-node pool held in single-port-read memories with
// registered read data. Split and lookup walk one tree level per cycle from
// the root; a leaf that split divides gets its eight children written in turn
// through the pool's write port, and the walk then steps into the new child.
// Set goes through the set, read and emit states, read through the read and
// emit states, then the response register. The user is to write configuration
// through cfg_we/cfg_idx/cfg_data while no item is in flight; not enforced.
module octree_point_descent_engine_core (
	input  logic                                clk,
	input  logic                                arst_n,
	octpd_in_if.sink                            in_ch,
	octpd_out_if.source                         out_ch,
	input  logic                                cfg_we,
	input  logic [octpd_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [octpd_pkg::DATA_W-1:0]        cfg_data
);
	import octpd_pkg::*;

	cfg_t  cfg_q;
	item_t q_item;
	qctl_t q_ctl;
	logic  q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_depth  <= DEPTH_W'(8);
			cfg_q.min_x      <= '0;
			cfg_q.min_y      <= '0;
			cfg_q.min_z      <= '0;
			cfg_q.max_x      <= COORD_W'(65536);
			cfg_q.max_y      <= COORD_W'(65536);
			cfg_q.max_z      <= COORD_W'(65536);
			cfg_q.empty_data <= '1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_MAX_DEPTH:  cfg_q.max_depth  <= cfg_data[DEPTH_W-1:0];
				CFG_MIN_X:      cfg_q.min_x      <= cfg_data[COORD_W-1:0];
				CFG_MIN_Y:      cfg_q.min_y      <= cfg_data[COORD_W-1:0];
				CFG_MIN_Z:      cfg_q.min_z      <= cfg_data[COORD_W-1:0];
				CFG_MAX_X:      cfg_q.max_x      <= cfg_data[COORD_W-1:0];
				CFG_MAX_Y:      cfg_q.max_y      <= cfg_data[COORD_W-1:0];
				CFG_MAX_Z:      cfg_q.max_z      <= cfg_data[COORD_W-1:0];
				CFG_EMPTY_DATA: cfg_q.empty_data <= cfg_data;
			endcase
		end
	end

	octpd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.q_item   (q_item),
		.q_ctl_in (q_ctl),
		.q_valid  (q_valid)
	);

	octpd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_item  (q_item),
		.q_valid (q_valid),
		.q_ctl   (q_ctl),
		.out_ch  (out_ch)
	);
endmodule

>>> tb/octpd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// octpd_checker
// Watches the request, response and register ports of the octree engine,
// keeps its own copy of the node pool, predicts each response and compares.
// ----------------------------------------------------------------------------
module octpd_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	octpd_in_if                                 in_ch,
	octpd_out_if                                out_ch,
	input  logic                                cfg_we,
	input  logic [octpd_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [octpd_pkg::DATA_W-1:0]        cfg_data,
	output int                                  errors,
	output int                                  outstanding,
	output int                                  checked,
	output int                                  full_hits,
	output int                                  bad_hits,
	output int                                  pool_used
);
	import octpd_pkg::*;

	typedef struct {
		logic [NODE_W-1:0]  node;
		logic [DEPTH_W-1:0] depth;
		logic [DATA_W-1:0]  data;
		logic               leaf;
		logic [NODE_W-1:0]  first;
		logic [NODE_W-1:0]  parent;
		logic [1:0]         status;
	} node_rec_t;

	// shadow pool
	logic [NODE_W-1:0]  kids   [POOL_NODES];
	logic               leaf_f [POOL_NODES];
	logic [NODE_W-1:0]  up     [POOL_NODES];
	logic [DEPTH_W-1:0] lvl    [POOL_NODES];
	logic [DATA_W-1:0]  word   [POOL_NODES];
	int                 used;

	logic [DEPTH_W-1:0] depth_cap;
	longint             box_lo [3];
	longint             box_hi [3];
	logic [DATA_W-1:0]  fresh_word;

	node_rec_t answer_q[$];

	function automatic node_rec_t node_view(int idx, logic [1:0] st);
		node_rec_t r;
		r.node   = NODE_W'(idx);
		r.depth  = lvl[idx];
		r.data   = word[idx];
		r.leaf   = leaf_f[idx];
		r.first  = leaf_f[idx] ? '0 : kids[idx];
		r.parent = up[idx];
		r.status = st;
		return r;
	endfunction

	function automatic node_rec_t descend_point(longint px, longint py, longint pz, bit grow);
		longint     lo [3];
		longint     hi [3];
		longint     p  [3];
		longint     mid;
		int         idx = 0;
		logic [1:0] st = STAT_OK;
		logic [2:0] oct;
		lo = box_lo;
		hi = box_hi;
		p[0] = px;
		p[1] = py;
		p[2] = pz;
		while (1) begin
			if (lvl[idx] >= depth_cap)
				break;
			if (leaf_f[idx]) begin
				if (!grow)
					break;
				if (used > POOL_NODES - CHILDREN) begin
					st = STAT_FULL;
					break;
				end
				kids[idx]   = NODE_W'(used);
				leaf_f[idx] = 1'b0;
				for (int c = used; c < used + CHILDREN; c++) begin
					kids[c]   = '0;
					leaf_f[c] = 1'b1;
					up[c]     = NODE_W'(idx);
					lvl[c]    = DEPTH_W'(lvl[idx] + 1);
					word[c]   = fresh_word;
				end
				used += CHILDREN;
			end
			oct = '0;
			for (int a = 0; a < 3; a++) begin
				// 33-bit sum, floor shift
				mid = (lo[a] + hi[a]) >>> 1;
				if (p[a] >= mid) begin
					oct[a] = 1'b1;
					lo[a]  = mid;
				end else begin
					hi[a] = mid;
				end
			end
			idx = kids[idx] + oct;
		end
		return node_view(idx, st);
	endfunction

	function automatic node_rec_t serve_item(op_t op, longint px, longint py, longint pz,
		int sel, logic [DATA_W-1:0] d);
		node_rec_t r;
		if (op == OP_SPLIT || op == OP_LOOKUP)
			return descend_point(px, py, pz, op == OP_SPLIT);
		if (sel >= used) begin
			r = '{default: '0};
			r.node   = NODE_W'(sel);
			r.status = STAT_BAD;
			return r;
		end
		if (op == OP_SET)
			word[sel] = d;
		return node_view(sel, STAT_OK);
	endfunction

	task automatic check_field(string name, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		node_rec_t r;
		node_rec_t nxt;
		if (!arst_n) begin
			for (int i = 0; i < POOL_NODES; i++) begin
				kids[i]   = '0;
				leaf_f[i] = 1'b0;
				up[i]     = '0;
				lvl[i]    = '0;
				word[i]   = '0;
			end
			depth_cap  = 4'd8;
			box_lo     = '{0, 0, 0};
			box_hi     = '{65536, 65536, 65536};
			fresh_word = '1;
			leaf_f[0]  = 1'b1;
			word[0]    = '1;
			used       = 1;
			errors     = 0;
			checked    = 0;
			full_hits  = 0;
			bad_hits   = 0;
			answer_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_MAX_DEPTH:  depth_cap  = cfg_data[DEPTH_W-1:0];
					CFG_MIN_X:      box_lo[0]  = $signed(cfg_data[31:0]);
					CFG_MIN_Y:      box_lo[1]  = $signed(cfg_data[31:0]);
					CFG_MIN_Z:      box_lo[2]  = $signed(cfg_data[31:0]);
					CFG_MAX_X:      box_hi[0]  = $signed(cfg_data[31:0]);
					CFG_MAX_Y:      box_hi[1]  = $signed(cfg_data[31:0]);
					CFG_MAX_Z:      box_hi[2]  = $signed(cfg_data[31:0]);
					CFG_EMPTY_DATA: fresh_word = cfg_data;
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready) begin
				nxt = serve_item(op_t'(in_ch.func), in_ch.point_x, in_ch.point_y,
					in_ch.point_z, in_ch.node_sel, in_ch.data_in);
				answer_q = {answer_q, nxt};
			end
			if (out_ch.valid && out_ch.ready) begin
				checked++;
				if (out_ch.status == STAT_FULL)
					full_hits++;
				if (out_ch.status == STAT_BAD)
					bad_hits++;
				if (answer_q.size() == 0) begin
					$error("response item with no request waiting");
					errors++;
				end else begin
					r = answer_q.pop_front();
					check_field("node_out", r.node, out_ch.node_out);
					check_field("depth_out", r.depth, out_ch.depth_out);
					check_field("data_out", r.data, out_ch.data_out);
					check_field("is_leaf", r.leaf, out_ch.is_leaf);
					check_field("first_child", r.first, out_ch.first_child);
					check_field("parent_out", r.parent, out_ch.parent_out);
					check_field("status", r.status, out_ch.status);
				end
			end
		end
		outstanding = answer_q.size();
		pool_used   = used;
	end

endmodule

>>> tb/tb_octree_point_descent_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_octree_point_descent_engine_core
// Drives directed and random split/lookup/set/read items through several
// register settings, with bursty requests and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_octree_point_descent_engine_core;
	import octpd_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [DATA_W-1:0]    cfg_data;

	int errors, outstanding, checked, full_hits, bad_hits, pool_used;
	int cycles = 0;
	int stall_mode = 0;

	longint box_lo [3];
	longint box_hi [3];
	logic signed [31:0] recent [16][3];

	octpd_in_if  in_ch ();
	octpd_out_if out_ch ();

	octree_point_descent_engine_core i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data)
	);

	octpd_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.out_ch     (out_ch),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.errors     (errors),
		.outstanding(outstanding),
		.checked    (checked),
		.full_hits  (full_hits),
		.bad_hits   (bad_hits),
		.pool_used  (pool_used)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// receiver: free-running, light or heavy stalls, mode chosen at random
	always @(posedge clk) begin
		if (cycles % 300 == 0)
			stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0:       out_ch.ready <= 1'b1;
			1:       out_ch.ready <= ($urandom_range(0, 1) == 0);
			default: out_ch.ready <= ($urandom_range(0, 7) != 0);
		endcase
	end

	task automatic issue(op_t op, logic signed [31:0] x, logic signed [31:0] y,
		logic signed [31:0] z, logic [NODE_W-1:0] sel, logic [DATA_W-1:0] d);
		in_ch.valid    <= 1'b1;
		in_ch.func     <= op;
		in_ch.point_x  <= x;
		in_ch.point_y  <= y;
		in_ch.point_z  <= z;
		in_ch.node_sel <= sel;
		in_ch.data_in  <= d;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	// registers only change with nothing in flight
	task automatic set_regs(logic [3:0] depth, longint lo [3], longint hi [3],
		logic [DATA_W-1:0] fill);
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		box_lo = lo;
		box_hi = hi;
		for (int i = 0; i < 8; i++) begin
			cfg_we  <= 1'b1;
			cfg_idx <= CFG_IDX_W'(i);
			case (i)
				CFG_MAX_DEPTH:  cfg_data <= DATA_W'(depth);
				CFG_EMPTY_DATA: cfg_data <= fill;
				default: cfg_data <= (i <= CFG_MIN_Z) ? DATA_W'(lo[i-1][31:0])
					: DATA_W'(hi[i-4][31:0]);
			endcase
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [31:0] pick_coord(int a);
		longint unsigned span;
		case ($urandom_range(0, 15))
			0:       return $urandom;
			1:       return 32'(box_lo[a]);
			2:       return 32'(box_hi[a]);
			default: begin
				if (box_lo[a] > box_hi[a])
					return $urandom;
				span = box_hi[a] - box_lo[a] + 1;
				return 32'(box_lo[a] + ({$urandom, $urandom} % span));
			end
		endcase
	endfunction

	task automatic random_items(int count);
		int burst;
		int r, slot;
		logic signed [31:0] pt [3];
		logic [NODE_W-1:0] sel;
		op_t op;
		burst = $urandom_range(1, 20);
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			op = (r < 30) ? OP_SPLIT : (r < 60) ? OP_LOOKUP : (r < 75) ? OP_SET : OP_READ;
			slot = $urandom_range(0, 15);
			// revisit earlier points often so lookups land in split regions
			if ($urandom_range(0, 3) == 0) begin
				pt = recent[slot];
			end else begin
				for (int a = 0; a < 3; a++)
					pt[a] = pick_coord(a);
				recent[slot] = pt;
			end
			sel = ($urandom_range(0, 7) == 0) ? NODE_W'($urandom)
				: NODE_W'($urandom_range(0, (pool_used + 8 > 4095) ? 4095 : pool_used + 8));
			issue(op, pt[0], pt[1], pt[2], sel, {$urandom, $urandom});
			if (--burst == 0) begin
				in_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				burst = $urandom_range(1, 20);
			end
		end
		in_ch.valid <= 1'b0;
	endtask

	initial begin
		longint lo [3];
		longint hi [3];
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_idx        = '0;
		cfg_data       = '0;
		in_ch.valid    = 1'b0;
		in_ch.func     = OP_READ;
		in_ch.point_x  = '0;
		in_ch.point_y  = '0;
		in_ch.point_z  = '0;
		in_ch.node_sel = '0;
		in_ch.data_in  = '0;
		for (int s = 0; s < 16; s++)
			recent[s] = '{32'sd0, 32'sd0, 32'sd0};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset tree, corners, extreme coordinates, bad indexes
		lo = '{0, 0, 0};
		hi = '{65536, 65536, 65536};
		box_lo = lo;
		box_hi = hi;
		issue(OP_READ, 0, 0, 0, 12'd0, '0);
		issue(OP_LOOKUP, 0, 0, 0, '0, '0);
		issue(OP_READ, 0, 0, 0, 12'd1, '0);
		issue(OP_SET, 0, 0, 0, 12'hfff, '1);
		set_regs(4'd2, lo, hi, 64'h0);
		issue(OP_SPLIT, 0, 0, 0, '0, '0);
		issue(OP_SPLIT, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, '0, '0);
		issue(OP_SPLIT, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, '0, '0);
		issue(OP_SPLIT, 32768, 32767, 32768, '0, '0);
		issue(OP_LOOKUP, 65535, 0, 65536, '0, '0);
		issue(OP_LOOKUP, 32'sh80000000, 32'sh80000000, 32'sh80000000, '0, '0);
		issue(OP_READ, 0, 0, 0, 12'd0, '0);
		issue(OP_READ, 0, 0, 0, 12'd9, '0);
		issue(OP_SET, 0, 0, 0, 12'd0, 64'ha5a5_5a5a_0f0f_f0f0);
		issue(OP_SET, 0, 0, 0, 12'd3, '1);
		issue(OP_SET, 0, 0, 0, 12'd4000, 64'h1);
		issue(OP_READ, 0, 0, 0, 12'd3, '0);
		issue(OP_READ, 0, 0, 0, 12'hfff, '0);

		// depth zero, widest box
		lo = '{-64'sd2147483648, -64'sd2147483648, -64'sd2147483648};
		hi = '{64'sd2147483647, 64'sd2147483647, 64'sd2147483647};
		set_regs(4'd0, lo, hi, {$urandom, $urandom});
		random_items(60);

		lo = '{-64'sd65536, 64'sd1000, -64'sd5};
		hi = '{64'sd131072, 64'sd70000, 64'sd5};
		set_regs(4'd4, lo, hi, {$urandom, $urandom});
		random_items(150);

		// inverted box, deepest limit
		lo = '{64'sd65536, 64'sd65536, -64'sd65536};
		hi = '{-64'sd65536, -64'sd65536, 64'sd65536};
		set_regs(4'd15, lo, hi, {$urandom, $urandom});
		random_items(120);

		lo = '{-64'sd262144, -64'sd262144, -64'sd262144};
		hi = '{64'sd0, 64'sd0, 64'sd0};
		set_regs(4'd8, lo, hi, 64'h0123_4567_89ab_cdef);
		random_items(150);

		// by now the pool runs out and splits report full
		lo = '{-64'sd2147483648, -64'sd2147483648, -64'sd2147483648};
		hi = '{64'sd2147483647, 64'sd2147483647, 64'sd2147483647};
		set_regs(4'd15, lo, hi, '1);
		random_items(150);

		while (outstanding != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		$display("checked %0d responses over seven register settings, pool grew to %0d nodes",
			checked, pool_used);
		$display("pool-full splits seen: %0d, out-of-range accesses: %0d", full_hits, bad_hits);
		if (errors == 0 && outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> filelist.f
hdl/octpd_pkg.sv
hdl/octpd_if.sv
hdl/octpd_front.sv
hdl/octpd_back.sv
hdl/octree_point_descent_engine_core.sv
tb/octpd_checker.sv
tb/tb_octree_point_descent_engine_core.sv
